FILE: rtl/core/rddl_pkg.sv
// shared types and constants for the reversible deque drop list unit
// item codes, controller states, result kinds and the control/status structs
// no dependencies
package rddl_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD    = 2'd0,
        FN_REVERSE = 2'd1,
        FN_DROP    = 2'd2,
        FN_FINISH  = 2'd3
    } func_t;

    typedef enum logic {
        ST_IDLE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RK_ELEM,
        RK_ERROR,
        RK_EMPTY
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic take;   // input beat this cycle
        logic step;   // output beat that is not the last of the run
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic finish; // current input item is a finish
        logic last;   // result on the output is the last of the run
    } stat_t;

endpackage

FILE: rtl/core/rddl_intf.sv
// valid/ready channel interfaces for the item input and the result output
// depends on rddl_pkg for field widths
interface rddl_item_if;
    logic                                valid;
    logic                                ready;
    logic        [rddl_pkg::FUNC_W-1:0]  func;
    logic signed [rddl_pkg::DATA_W-1:0]  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface rddl_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [rddl_pkg::DATA_W-1:0]  item_value;
    logic                                is_error;
    logic                                is_empty;
    logic                                last;

    modport source (output valid, output item_value, output is_error,
                    output is_empty, output last, input ready);
    modport sink   (input valid, input item_value, input is_error,
                    input is_empty, input last, output ready);
endinterface

FILE: rtl/core/reversible_deque_drop_list_unit.sv
// reversible deque drop list unit: list buffer with a direction flag
// and a sticky error, streaming its contents on a finish item
// channel "cmd" takes items, channel "res" gives results (both valid/ready)
// depends on rddl_pkg, rddl_intf, rddl_ctrl and rddl_datapath
//
// an item beat carries func (load, reverse, drop, finish) and value
// load, reverse and drop give no result and leave cmd.ready high
// a finish beat moves the list into the stream registers and clears it;
// the first result is on res in the cycle after the finish beat, then one
// result per cycle while res.ready is high
// the run is a single error result if a drop hit an empty list or a load
// hit a full store since the last finish, a single empty result if the
// list holds nothing, else the elements in logical order, last on the final
// cmd.ready is low after a finish beat until the last result beat; a stall
// on res holds the current result and the stream position
// element rate is set by the single read port of the element memory,
// whose registered read data is the result data register
// reset clears pointers, count, flags and the state machine; the memory
// needs no clearing since only written entries are ever read
module reversible_deque_drop_list_unit
#(
    parameter int DEPTH = rddl_pkg::DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    rddl_item_if.sink     cmd,
    rddl_result_if.source res
);

    rddl_pkg::cmd_t  ctl;
    rddl_pkg::stat_t stat;

    rddl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .stat      (stat),
        .cmd       (ctl)
    );

    rddl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctl),
        .stat       (stat),
        .func       (cmd.func),
        .value      (cmd.value),
        .item_value (res.item_value),
        .is_error   (res.is_error),
        .is_empty   (res.is_empty),
        .last       (res.last)
    );

    // items are never taken while a run is on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !(res.valid && cmd.ready))
    else $error("item channel open during a result run");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready && (cmd.func == rddl_pkg::FN_FINISH) |=> res.valid)
    else $error("finish beat not followed by a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready && res.last |=> cmd.ready && !res.valid)
    else $error("run did not end after its last beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.is_error || res.is_empty) |->
            res.last && (res.item_value == '0) && !(res.is_error && res.is_empty))
    else $error("malformed error or empty result");

endmodule

FILE: rtl/core/rddl_ctrl.sv
// controller: idle/stream state machine that drives both handshakes
// depends on rddl_pkg
module rddl_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  rddl_pkg::stat_t stat,
    output rddl_pkg::cmd_t  cmd
);

    rddl_pkg::state_t state_reg;
    rddl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rddl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rddl_pkg::ST_IDLE:
            begin
                if (in_valid && stat.finish)
                begin
                    state_next = rddl_pkg::ST_OUT;
                end
            end
            rddl_pkg::ST_OUT:
            begin
                if (out_ready && stat.last)
                begin
                    state_next = rddl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rddl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            rddl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            rddl_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                cmd.step  = out_ready && !stat.last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/rddl_datapath.sv
// datapath: element memory, list pointers, flags and the result stream registers
// depends on rddl_pkg; commanded by rddl_ctrl
module rddl_datapath
#(
    parameter int DEPTH = rddl_pkg::DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rddl_pkg::cmd_t                     cmd,
    output rddl_pkg::stat_t                    stat,
    input  logic        [rddl_pkg::FUNC_W-1:0] func,
    input  logic signed [rddl_pkg::DATA_W-1:0] value,
    output logic signed [rddl_pkg::DATA_W-1:0] item_value,
    output logic                               is_error,
    output logic                               is_empty,
    output logic                               last
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] PTR_TOP  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    // a + b modulo DEPTH, both operands below DEPTH
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[PW-1:0];
    endfunction

    logic [rddl_pkg::DATA_W-1:0] mem [DEPTH];
    logic [rddl_pkg::DATA_W-1:0] rd_data_reg;

    logic [PW-1:0]   front_reg, front_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            rev_reg, rev_next;
    logic            err_reg, err_next;

    // stream state for a finish run
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic            srev_reg, srev_next;
    rddl_pkg::kind_t kind_reg, kind_next;

    logic            wr_en;
    logic [PW-1:0]   wr_addr;
    logic            rd_en;
    logic [PW-1:0]   rd_addr;
    logic [PW-1:0]   step_ptr;
    logic [PW-1:0]   tail_ptr;
    logic            is_load, is_rev, is_drop, is_fin;

    assign is_load = (func == rddl_pkg::FN_LOAD);
    assign is_rev  = (func == rddl_pkg::FN_REVERSE);
    assign is_drop = (func == rddl_pkg::FN_DROP);
    assign is_fin  = (func == rddl_pkg::FN_FINISH);

    assign wr_addr  = wrap_add(front_reg, count_reg[PW-1:0]);
    assign tail_ptr = wrap_add(front_reg, count_reg[PW-1:0] - 1'b1);

    always_comb
    begin
        if (srev_reg)
        begin
            step_ptr = (rptr_reg == '0) ? PTR_TOP : rptr_reg - 1'b1;
        end
        else
        begin
            step_ptr = (rptr_reg == PTR_TOP) ? '0 : rptr_reg + 1'b1;
        end
    end

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        err_next   = err_reg;
        rptr_next  = rptr_reg;
        rem_next   = rem_reg;
        srev_next  = srev_reg;
        kind_next  = kind_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = step_ptr;

        if (cmd.take)
        begin
            if (is_load)
            begin
                if (count_reg == CNT_FULL)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            else if (is_rev)
            begin
                rev_next = !rev_reg;
            end
            else if (is_drop)
            begin
                if (count_reg == '0)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    if (!rev_reg)
                    begin
                        front_next = wrap_add(front_reg, PW'(1));
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            else
            begin
                // finish: snapshot the list into the stream registers, clear it
                rem_next  = count_reg;
                srev_next = rev_reg;
                rptr_next = rev_reg ? tail_ptr : front_reg;
                rd_addr   = rev_reg ? tail_ptr : front_reg;
                if (err_reg)
                begin
                    kind_next = rddl_pkg::RK_ERROR;
                end
                else if (count_reg == '0)
                begin
                    kind_next = rddl_pkg::RK_EMPTY;
                end
                else
                begin
                    kind_next = rddl_pkg::RK_ELEM;
                    rd_en     = 1'b1;
                end
                front_next = '0;
                count_next = '0;
                rev_next   = 1'b0;
                err_next   = 1'b0;
            end
        end
        else if (cmd.step)
        begin
            rptr_next = step_ptr;
            rem_next  = rem_reg - 1'b1;
            rd_en     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
            err_reg   <= 1'b0;
            rptr_reg  <= '0;
            rem_reg   <= '0;
            srev_reg  <= 1'b0;
            kind_reg  <= rddl_pkg::RK_EMPTY;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            err_reg   <= err_next;
            rptr_reg  <= rptr_next;
            rem_reg   <= rem_next;
            srev_reg  <= srev_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= $unsigned(value);
        end
    end

    // registered read port doubles as the output data register
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        item_value = '0;
        is_error   = 1'b0;
        is_empty   = 1'b0;
        last       = 1'b1;
        case (kind_reg)
            rddl_pkg::RK_ELEM:
            begin
                item_value = $signed(rd_data_reg);
                last       = (rem_reg == CW'(1));
            end
            rddl_pkg::RK_ERROR:
            begin
                is_error = 1'b1;
            end
            rddl_pkg::RK_EMPTY:
            begin
                is_empty = 1'b1;
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

    assign stat.finish = is_fin;
    assign stat.last   = last;

endmodule
